// ===== rtl/core/vcps_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vcps_pkg: shared types and constants of the variable-coefficient stencil
//
// Payload beats, line store entries, stencil windows, multiplier operands,
// register indexes and the sequencer states used by the stencil core.
// ============================================================================
package vcps_pkg;

    // Field and register widths.
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = 7;
    localparam int MASK_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Default patch limits handed to the top level parameters.
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Register reset values.
    localparam logic [DIM_W-1:0]  RST_PATCH_WIDTH  = 7'd8;
    localparam logic [DIM_W-1:0]  RST_PATCH_HEIGHT = 7'd8;
    localparam logic [MASK_W-1:0] RST_NB_MASK      = 4'd0;
    localparam logic [DATA_W-1:0] RST_INV_SQ       = 32'h0001_0000;

    // Bit positions in the neighbour mask.
    localparam int NB_WEST  = 0;
    localparam int NB_EAST  = 1;
    localparam int NB_SOUTH = 2;
    localparam int NB_NORTH = 3;

    // Datapath widths. A face sum or a difference has a magnitude of at most
    // 2^32, so magnitudes take MAG_W bits and their products PROD_W bits.
    localparam int MAG_W    = DATA_W + 1;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int PART_W   = PROD_W + 1;
    localparam int ACC_W    = PROD_W + DATA_W + 2;
    localparam int HI_SHIFT = MAG_W;

    // Rounding: the total carries 3*FRAC_BITS fraction bits and a pending
    // halving of the face sums.
    localparam int RND_SHIFT = 2 * FRAC_BITS + 1;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (2 * FRAC_BITS);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATCH_WIDTH    = 3'd0,
        CFG_PATCH_HEIGHT   = 3'd1,
        CFG_NEIGHBOUR_MASK = 3'd2,
        CFG_INV_DX_SQ      = 3'd3,
        CFG_INV_DY_SQ      = 3'd4
    } t_cfg_index;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_MX_E,
        ST_MX_W,
        ST_AX,
        ST_XABS,
        ST_KX_LO,
        ST_KX_HI,
        ST_MY_N,
        ST_MY_S,
        ST_AY,
        ST_YABS,
        ST_KY_LO,
        ST_KY_HI,
        ST_FIN,
        ST_RND
    } t_state;

    // Input beat: one padded cell.
    typedef struct packed {
        logic signed [DATA_W-1:0] u_value;
        logic signed [DATA_W-1:0] beta_value;
    } t_in_item;

    // Output beat: one interior cell.
    typedef struct packed {
        logic signed [DATA_W-1:0] f_value;
        logic                     cell_last;
    } t_out_item;

    // One line store entry: newest line (l0) and the line before it (l1).
    typedef struct packed {
        logic [DATA_W-1:0] u_l0;
        logic [DATA_W-1:0] u_l1;
        logic [DATA_W-1:0] b_l0;
        logic [DATA_W-1:0] b_l1;
    } t_line_entry;

    // The part of a 3x3 window that the stencil and the column shift need.
    typedef struct packed {
        logic signed [DATA_W-1:0] sc;
        logic signed [DATA_W-1:0] se;
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] nc;
        logic signed [DATA_W-1:0] ne;
    } t_window;

    // Sign-magnitude operand pair of one face term.
    typedef struct packed {
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic             neg;
    } t_mul_op;

    // Position flags of the cell in flight.
    typedef struct packed {
        logic interior;
        logic last;
        logic ghost_w;
        logic ghost_e;
        logic ghost_s;
        logic ghost_n;
    } t_cell_flags;

endpackage

// ===== rtl/core/varcoef_poisson_stencil_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// varcoef_poisson_stencil_top: variable-coefficient five-point operator
//
// Streams a ghost-padded patch in raster order and returns the saturated
// Q16.16 operator value of every interior cell.
// ============================================================================
//
// Padded cells arrive one beat at a time, west to east and then south to
// north, and each interior cell yields one result beat, with cell_last set
// on the last one of the patch. Ghost positions are taken at one beat per
// cycle while no interior cell holds the core. An interior cell occupies the
// core from its accept to the loading of its result: the line store read,
// the operand set-up, the multiply-accumulate sequence on the single shared
// 33x33 multiplier, and rounding and saturation. The output register lets
// the next cell be accepted while a result still waits to be taken. Two
// lines of history live in one line store of MAX_WIDTH+2 entries with a
// registered read; the store needs no clearing after reset.
module varcoef_poisson_stencil_top
    import vcps_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int LINE_LEN = MAX_WIDTH + 2;
    localparam int CW       = $clog2(LINE_LEN);
    localparam int RW       = $clog2(MAX_HEIGHT + 2);
    localparam int XW       = (CW > DIM_W) ? CW : DIM_W;
    localparam int YW       = (RW > DIM_W) ? RW : DIM_W;

    // Sign extension of a data word to the difference width.
    function automatic logic signed [MAG_W:0] sx(input logic [DATA_W-1:0] v);
        return {{(MAG_W+1-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // Magnitude of a signed difference or sum; it never exceeds 2^32.
    function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W:0] v);
        logic [MAG_W:0] m;
        m = v[MAG_W] ? (MAG_W+1)'(-v) : (MAG_W+1)'(v);
        return m[MAG_W-1:0];
    endfunction

    // Configuration registers.
    logic [DIM_W-1:0]  r_patch_width;
    logic [DIM_W-1:0]  r_patch_height;
    logic [MASK_W-1:0] r_nb_mask;
    logic [DATA_W-1:0] r_inv_dx_sq;
    logic [DATA_W-1:0] r_inv_dy_sq;

    // Control state.
    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    t_cell_flags       r_flags;
    t_cell_flags       w_flags_in;
    logic              r_out_valid;

    // Item in flight and line store.
    t_in_item          r_item;
    logic [CW-1:0]     r_item_col;
    t_line_entry       r_line_mem [LINE_LEN];
    t_line_entry       r_line_rd;
    t_line_entry       w_line_wr;

    // Windows.
    t_window           r_u_win;
    t_window           r_b_win;
    t_window           n_u_win;
    t_window           n_b_win;

    // Arithmetic.
    t_mul_op           r_op_e;
    t_mul_op           r_op_w;
    t_mul_op           r_op_n;
    t_mul_op           r_op_s;
    logic [MAG_W-1:0]  w_mul_a;
    logic [MAG_W-1:0]  w_mul_b;
    logic              w_mul_neg;
    logic              w_mul_hi;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] r_prod;
    logic              r_pneg;
    logic              r_phi;
    logic signed [PART_W-1:0] r_part;
    logic signed [PART_W-1:0] n_part;
    logic [PART_W-1:0] w_part_mag;
    logic [PART_W-1:0] w_part_abs;
    logic [PROD_W-1:0] r_mag;
    logic              r_mag_neg;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0]  w_acc_mag;
    logic signed [ACC_W-1:0] w_shifted;
    logic              w_fits;
    logic [DATA_W-1:0] w_f_value;
    t_out_item         r_out;

    // Control strobes.
    logic              w_in_acc;
    logic              c_line_we;
    logic              c_prep_en;
    logic              c_part_en;
    logic              c_mag_en;
    logic              c_acc_en;
    logic              c_out_load;

    // Geometry.
    logic [XW-1:0]     w_pw_ext;
    logic [XW-1:0]     w_pw_clamp;
    logic [YW-1:0]     w_ph_ext;
    logic [YW-1:0]     w_ph_clamp;
    logic [CW-1:0]     w_pw_p1;
    logic [RW-1:0]     w_ph_p1;
    logic              w_row_end;
    logic              w_last_row;

    // Operand set-up.
    logic signed [MAG_W:0] w_uc;
    logic signed [MAG_W:0] w_uc2;
    logic signed [MAG_W:0] w_d_e;
    logic signed [MAG_W:0] w_d_w;
    logic signed [MAG_W:0] w_d_n;
    logic signed [MAG_W:0] w_d_s;
    logic signed [MAG_W:0] w_s_e;
    logic signed [MAG_W:0] w_s_w;
    logic signed [MAG_W:0] w_s_n;
    logic signed [MAG_W:0] w_s_s;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_width  <= RST_PATCH_WIDTH;
            r_patch_height <= RST_PATCH_HEIGHT;
            r_nb_mask      <= RST_NB_MASK;
            r_inv_dx_sq    <= RST_INV_SQ;
            r_inv_dy_sq    <= RST_INV_SQ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PATCH_WIDTH:    r_patch_width  <= i_cfg_data[DIM_W-1:0];
                CFG_PATCH_HEIGHT:   r_patch_height <= i_cfg_data[DIM_W-1:0];
                CFG_NEIGHBOUR_MASK: r_nb_mask      <= i_cfg_data[MASK_W-1:0];
                CFG_INV_DX_SQ:      r_inv_dx_sq    <= i_cfg_data;
                CFG_INV_DY_SQ:      r_inv_dy_sq    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Patch size clamped to one cell at least and to the store size at most.
    always_comb begin
        w_pw_ext = XW'(r_patch_width);
        if (w_pw_ext == '0) begin
            w_pw_clamp = XW'(1);
        end else if (w_pw_ext > XW'(MAX_WIDTH)) begin
            w_pw_clamp = XW'(MAX_WIDTH);
        end else begin
            w_pw_clamp = w_pw_ext;
        end
        w_ph_ext = YW'(r_patch_height);
        if (w_ph_ext == '0) begin
            w_ph_clamp = YW'(1);
        end else if (w_ph_ext > YW'(MAX_HEIGHT)) begin
            w_ph_clamp = YW'(MAX_HEIGHT);
        end else begin
            w_ph_clamp = w_ph_ext;
        end
    end

    assign w_pw_p1    = CW'(w_pw_clamp) + CW'(1);
    assign w_ph_p1    = RW'(w_ph_clamp) + RW'(1);
    assign w_row_end  = (r_col >= w_pw_p1);
    assign w_last_row = (r_row >= w_ph_p1);

    // Position flags of the arriving cell.
    always_comb begin
        w_flags_in.interior = (r_col >= CW'(2)) && (r_row >= RW'(2))
                            && (r_col <= w_pw_p1) && (r_row <= w_ph_p1);
        w_flags_in.last     = (r_col == w_pw_p1) && (r_row == w_ph_p1);
        w_flags_in.ghost_w  = (r_col == CW'(2)) && !r_nb_mask[NB_WEST];
        w_flags_in.ghost_e  = (r_col == w_pw_p1) && !r_nb_mask[NB_EAST];
        w_flags_in.ghost_s  = (r_row == RW'(2)) && !r_nb_mask[NB_SOUTH];
        w_flags_in.ghost_n  = (r_row == w_ph_p1) && !r_nb_mask[NB_NORTH];
    end

    // Input handshake: a ghost cell in the read cycle lets the next beat in.
    assign o_in_stall = !((r_state == ST_IDLE) || ((r_state == ST_READ) && !r_flags.interior));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Raster position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flags <= '0;
        end else if (w_in_acc) begin
            r_flags <= w_flags_in;
            if (w_row_end) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Capture the accepted beat.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item     <= i_in_data;
            r_item_col <= r_col;
        end
    end

    // Line store: read on accept, write back the shifted lines in the next cycle.
    always_comb begin
        w_line_wr.u_l0 = r_item.u_value;
        w_line_wr.u_l1 = r_line_rd.u_l0;
        w_line_wr.b_l0 = r_item.beta_value;
        w_line_wr.b_l1 = r_line_rd.b_l0;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_line_rd <= r_line_mem[r_col];
        end
        if (c_line_we) begin
            r_line_mem[r_item_col] <= w_line_wr;
        end
    end

    // Window column shift with the two stored lines and the new cell.
    always_comb begin
        n_u_win.sc = r_u_win.se;
        n_u_win.se = r_line_rd.u_l1;
        n_u_win.w  = r_u_win.c;
        n_u_win.c  = r_u_win.e;
        n_u_win.e  = r_line_rd.u_l0;
        n_u_win.nc = r_u_win.ne;
        n_u_win.ne = r_item.u_value;
        n_b_win.sc = r_b_win.se;
        n_b_win.se = r_line_rd.b_l1;
        n_b_win.w  = r_b_win.c;
        n_b_win.c  = r_b_win.e;
        n_b_win.e  = r_line_rd.b_l0;
        n_b_win.nc = r_b_win.ne;
        n_b_win.ne = r_item.beta_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_win <= '0;
            r_b_win <= '0;
        end else if (c_line_we) begin
            r_u_win <= n_u_win;
            r_b_win <= n_b_win;
        end
    end

    // Face sums and differences; a missing neighbour takes the negated center value.
    always_comb begin
        w_uc  = sx(r_u_win.c);
        w_uc2 = w_uc <<< 1;
        w_d_e = r_flags.ghost_e ? -w_uc2 : sx(r_u_win.e) - w_uc;
        w_d_w = r_flags.ghost_w ?  w_uc2 : w_uc - sx(r_u_win.w);
        w_d_n = r_flags.ghost_n ? -w_uc2 : sx(r_u_win.nc) - w_uc;
        w_d_s = r_flags.ghost_s ?  w_uc2 : w_uc - sx(r_u_win.sc);
        w_s_e = sx(r_b_win.c) + sx(r_b_win.e);
        w_s_w = sx(r_b_win.c) + sx(r_b_win.w);
        w_s_n = sx(r_b_win.c) + sx(r_b_win.nc);
        w_s_s = sx(r_b_win.c) + sx(r_b_win.sc);
    end

    // West and south terms enter with a minus sign.
    always_ff @(posedge i_clk) begin
        if (c_prep_en) begin
            r_op_e <= '{a: mag(w_s_e), b: mag(w_d_e), neg: w_s_e[MAG_W] ^ w_d_e[MAG_W]};
            r_op_w <= '{a: mag(w_s_w), b: mag(w_d_w), neg: ~(w_s_w[MAG_W] ^ w_d_w[MAG_W])};
            r_op_n <= '{a: mag(w_s_n), b: mag(w_d_n), neg: w_s_n[MAG_W] ^ w_d_n[MAG_W]};
            r_op_s <= '{a: mag(w_s_s), b: mag(w_d_s), neg: ~(w_s_s[MAG_W] ^ w_d_s[MAG_W])};
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        w_mul_neg = 1'b0;
        w_mul_hi  = 1'b0;
        case (r_state)
            ST_MX_E: begin
                w_mul_a   = r_op_e.a;
                w_mul_b   = r_op_e.b;
                w_mul_neg = r_op_e.neg;
            end
            ST_MX_W: begin
                w_mul_a   = r_op_w.a;
                w_mul_b   = r_op_w.b;
                w_mul_neg = r_op_w.neg;
            end
            ST_MY_N: begin
                w_mul_a   = r_op_n.a;
                w_mul_b   = r_op_n.b;
                w_mul_neg = r_op_n.neg;
            end
            ST_MY_S: begin
                w_mul_a   = r_op_s.a;
                w_mul_b   = r_op_s.b;
                w_mul_neg = r_op_s.neg;
            end
            ST_KX_LO: begin
                w_mul_a   = r_mag[MAG_W-1:0];
                w_mul_b   = MAG_W'(r_inv_dx_sq);
                w_mul_neg = r_mag_neg;
            end
            ST_KX_HI: begin
                w_mul_a   = r_mag[PROD_W-1:MAG_W];
                w_mul_b   = MAG_W'(r_inv_dx_sq);
                w_mul_neg = r_mag_neg;
                w_mul_hi  = 1'b1;
            end
            ST_KY_LO: begin
                w_mul_a   = r_mag[MAG_W-1:0];
                w_mul_b   = MAG_W'(r_inv_dy_sq);
                w_mul_neg = r_mag_neg;
            end
            ST_KY_HI: begin
                w_mul_a   = r_mag[PROD_W-1:MAG_W];
                w_mul_b   = MAG_W'(r_inv_dy_sq);
                w_mul_neg = r_mag_neg;
                w_mul_hi  = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Product register; its sign and alignment travel with it.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_pneg <= w_mul_neg;
        r_phi  <= w_mul_hi;
    end

    // Partial sum of one direction: two face terms.
    assign w_part_mag = PART_W'(r_prod);
    assign n_part = ((r_state == ST_AX) || (r_state == ST_AY) ? r_part : '0)
                  + (r_pneg ? -w_part_mag : w_part_mag);
    assign w_part_abs = r_part[PART_W-1] ? PART_W'(-r_part) : PART_W'(r_part);

    always_ff @(posedge i_clk) begin
        if (c_part_en) begin
            r_part <= n_part;
        end
        if (c_mag_en) begin
            r_mag     <= w_part_abs[PROD_W-1:0];
            r_mag_neg <= r_part[PART_W-1];
        end
    end

    // Total accumulator, seeded with the rounding constant.
    assign w_acc_mag = r_phi ? (ACC_W'(r_prod) << HI_SHIFT) : ACC_W'(r_prod);
    assign n_acc = ((r_state == ST_KX_HI) ? ROUND_HALF : r_acc)
                 + (r_pneg ? -w_acc_mag : w_acc_mag);

    always_ff @(posedge i_clk) begin
        if (c_acc_en) begin
            r_acc <= n_acc;
        end
    end

    // Scale back to Q16.16 and saturate.
    assign w_shifted = r_acc >>> RND_SHIFT;
    assign w_fits    = (&w_shifted[ACC_W-1:DATA_W-1]) || ~(|w_shifted[ACC_W-1:DATA_W-1]);
    assign w_f_value = w_fits ? w_shifted[DATA_W-1:0]
                              : (w_shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_out.f_value   <= w_f_value;
            r_out.cell_last <= r_flags.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and datapath strobes.
    always_comb begin
        n_state    = r_state;
        c_line_we  = 1'b0;
        c_prep_en  = 1'b0;
        c_part_en  = 1'b0;
        c_mag_en   = 1'b0;
        c_acc_en   = 1'b0;
        c_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                c_line_we = 1'b1;
                if (r_flags.interior) begin
                    n_state = ST_PREP;
                end else if (w_in_acc) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PREP: begin
                c_prep_en = 1'b1;
                n_state   = ST_MX_E;
            end
            ST_MX_E: begin
                n_state = ST_MX_W;
            end
            ST_MX_W: begin
                c_part_en = 1'b1;
                n_state   = ST_AX;
            end
            ST_AX: begin
                c_part_en = 1'b1;
                n_state   = ST_XABS;
            end
            ST_XABS: begin
                c_mag_en = 1'b1;
                n_state  = ST_KX_LO;
            end
            ST_KX_LO: begin
                n_state = ST_KX_HI;
            end
            ST_KX_HI: begin
                c_acc_en = 1'b1;
                n_state  = ST_MY_N;
            end
            ST_MY_N: begin
                c_acc_en = 1'b1;
                n_state  = ST_MY_S;
            end
            ST_MY_S: begin
                c_part_en = 1'b1;
                n_state   = ST_AY;
            end
            ST_AY: begin
                c_part_en = 1'b1;
                n_state   = ST_YABS;
            end
            ST_YABS: begin
                c_mag_en = 1'b1;
                n_state  = ST_KY_LO;
            end
            ST_KY_LO: begin
                n_state = ST_KY_HI;
            end
            ST_KY_HI: begin
                c_acc_en = 1'b1;
                n_state  = ST_FIN;
            end
            ST_FIN: begin
                c_acc_en = 1'b1;
                n_state  = ST_RND;
            end
            ST_RND: begin
                if (!r_out_valid || !i_out_stall) begin
                    c_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
